// ----- rtl/fcull_pkg.sv -----
// Shared constants, types and status groups of the frustum box culling block.
`default_nettype none
package fcull_pkg;

	localparam int COEF_BITS   = 24;
	localparam int COORD_BITS  = 24;
	localparam int NUM_PLANES  = 6;
	localparam int NUM_AXES    = 3;
	localparam int NUM_COMP    = 4;
	localparam int COL_BITS    = 2;
	localparam int STORE_BITS  = COEF_BITS + 1;
	localparam int PROD_BITS   = STORE_BITS + COORD_BITS;
	localparam int SUM_BITS    = PROD_BITS + 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TEST = 1'b1
	} cmd_t;

	typedef logic signed [COEF_BITS-1:0]  elem_t;
	typedef logic signed [STORE_BITS-1:0] coef_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		cmd_t                           cmd;
		logic [COL_BITS-1:0]            col;
		coef_t  [NUM_PLANES-1:0]        comp;
		coord_t [NUM_AXES-1:0]          lo;
		coord_t [NUM_AXES-1:0]          hi;
	} item_t;

	typedef struct packed {
		logic [QCNT_BITS-1:0] count;
		logic                 full;
		logic                 empty;
	} q_status_t;

	typedef struct packed {
		logic pop;
		logic pop_test;
		logic valid_s1;
	} bk_status_t;

endpackage
`default_nettype wire

// ----- rtl/fcull_front.sv -----
// Front end: accept transactions, decode the command and form plane components of a load.
`default_nettype none
module fcull_front (
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [1:0]         column_index,
	input  wire fcull_pkg::elem_t   elem_r0,
	input  wire fcull_pkg::elem_t   elem_r1,
	input  wire fcull_pkg::elem_t   elem_r2,
	input  wire fcull_pkg::elem_t   elem_r3,
	input  wire fcull_pkg::coord_t  min_x,
	input  wire fcull_pkg::coord_t  min_y,
	input  wire fcull_pkg::coord_t  min_z,
	input  wire fcull_pkg::coord_t  max_x,
	input  wire fcull_pkg::coord_t  max_y,
	input  wire fcull_pkg::coord_t  max_z,
	input  wire fcull_pkg::q_status_t q_st,
	output logic                    push,
	output fcull_pkg::item_t        item
);
	import fcull_pkg::*;

	coef_t r3_ext;

	assign in_stall = q_st.full;
	assign push     = in_valid && !q_st.full;

	always_comb begin
		r3_ext   = STORE_BITS'(elem_r3);
		item.cmd = (command == 1'b1) ? CMD_TEST : CMD_LOAD;
		item.col = COL_BITS'(column_index);
		// plane pairs: row3 plus and minus rows 0, 1, 2
		item.comp[0] = r3_ext + STORE_BITS'(elem_r0);
		item.comp[1] = r3_ext - STORE_BITS'(elem_r0);
		item.comp[2] = r3_ext + STORE_BITS'(elem_r1);
		item.comp[3] = r3_ext - STORE_BITS'(elem_r1);
		item.comp[4] = r3_ext + STORE_BITS'(elem_r2);
		item.comp[5] = r3_ext - STORE_BITS'(elem_r2);
		item.lo[0]   = min_x;
		item.lo[1]   = min_y;
		item.lo[2]   = min_z;
		item.hi[0]   = max_x;
		item.hi[1]   = max_y;
		item.hi[2]   = max_z;
	end

endmodule
`default_nettype wire

// ----- rtl/fcull_queue.sv -----
// Short register queue that decouples the front end from the back end.
`default_nettype none
module fcull_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire fcull_pkg::item_t   item_in,
	input  wire logic               pop,
	output fcull_pkg::item_t        item_out,
	output fcull_pkg::q_status_t    q_st
);
	import fcull_pkg::*;

	item_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign item_out   = mem_q[rd_ptr_q];
	assign q_st.count = count_q;
	assign q_st.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign q_st.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fcull_back.sv -----
// Back end: plane store, per-plane multiply and sum lanes, and the result register.
`default_nettype none
module fcull_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fcull_pkg::item_t   item,
	input  wire fcull_pkg::q_status_t q_st,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    visible,
	output fcull_pkg::bk_status_t   bk_st
);
	import fcull_pkg::*;

	coef_t                       coef_q   [NUM_PLANES][NUM_COMP];
	logic signed [PROD_BITS-1:0] prod_d   [NUM_PLANES][NUM_AXES];
	logic signed [PROD_BITS-1:0] prod_s1  [NUM_PLANES][NUM_AXES];
	coef_t                       w_s1     [NUM_PLANES];
	logic signed [SUM_BITS-1:0]  sum_d    [NUM_PLANES];
	logic [NUM_PLANES-1:0]       neg_d;
	logic [NUM_PLANES-1:0]       neg_s2;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        out_valid_q;
	logic                        visible_q;
	logic                        adv;
	logic                        pop_test;

	// advance the whole pipe unless a result is held at the output
	assign adv      = !(out_valid_q && out_stall);
	assign pop      = !q_st.empty && adv;
	assign pop_test = pop && (item.cmd == CMD_TEST);

	assign out_valid      = out_valid_q;
	assign visible        = visible_q;
	assign bk_st.pop      = pop;
	assign bk_st.pop_test = pop_test;
	assign bk_st.valid_s1 = valid_s1;

	always_comb begin
		coord_t vtx;
		vtx = '0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				// positive vertex: max where the coefficient is not negative
				vtx = coef_q[p][k][STORE_BITS-1] ? item.lo[k] : item.hi[k];
				prod_d[p][k] = PROD_BITS'(coef_q[p][k]) * PROD_BITS'(vtx);
			end
		end
	end

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			sum_d[p] = SUM_BITS'(prod_s1[p][0]) + SUM_BITS'(prod_s1[p][1])
			         + SUM_BITS'(prod_s1[p][2]) + SUM_BITS'(w_s1[p]);
			neg_d[p] = sum_d[p][SUM_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int c = 0; c < NUM_COMP; c++) begin
					coef_q[p][c] <= '0;
				end
			end
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && (item.cmd == CMD_LOAD)) begin
				for (int p = 0; p < NUM_PLANES; p++) begin
					coef_q[p][item.col] <= item.comp[p];
				end
			end
			if (adv) begin
				valid_s1    <= pop_test;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					prod_s1[p][k] <= prod_d[p][k];
				end
				w_s1[p] <= coef_q[p][NUM_COMP-1];
			end
			neg_s2    <= neg_d;
			visible_q <= ~|neg_s2;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/frustum_box_culling_top.sv -----
// Top level of the frustum box culling block: front end, queue and back end.
// A test goes from the queue through the product, sign and result registers to visible.
// Throughput: one transaction per cycle while the output is not stalled, set by six
// parallel plane lanes (three multiplies, one four-term sum each); a load takes one
// queue slot and no result. Reset clears the plane store to zero (every box visible
// until loaded) and empties the queue and the pipeline at once.
`default_nettype none
module frustum_box_culling_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [1:0]         column_index,
	input  wire fcull_pkg::elem_t   elem_r0,
	input  wire fcull_pkg::elem_t   elem_r1,
	input  wire fcull_pkg::elem_t   elem_r2,
	input  wire fcull_pkg::elem_t   elem_r3,
	input  wire fcull_pkg::coord_t  min_x,
	input  wire fcull_pkg::coord_t  min_y,
	input  wire fcull_pkg::coord_t  min_z,
	input  wire fcull_pkg::coord_t  max_x,
	input  wire fcull_pkg::coord_t  max_y,
	input  wire fcull_pkg::coord_t  max_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    visible
);
	import fcull_pkg::*;

	item_t      fe_item;
	item_t      q_item;
	q_status_t  q_st;
	bk_status_t bk_st;
	logic       push;
	logic       pop;

	// Front end: take a transaction whenever the queue has room, and decode it.
	fcull_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.column_index (column_index),
		.elem_r0      (elem_r0),
		.elem_r1      (elem_r1),
		.elem_r2      (elem_r2),
		.elem_r3      (elem_r3),
		.min_x        (min_x),
		.min_y        (min_y),
		.min_z        (min_z),
		.max_x        (max_x),
		.max_y        (max_y),
		.max_z        (max_z),
		.q_st         (q_st),
		.push         (push),
		.item         (fe_item)
	);

	// Queue: hold decoded transactions in order while the back end is stalled.
	fcull_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (fe_item),
		.pop      (pop),
		.item_out (q_item),
		.q_st     (q_st)
	);

	// Back end: loads update the plane store in queue order, so a test always sees
	// every load that was accepted before it and none after.
	fcull_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (q_item),
		.q_st      (q_st),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.visible   (visible),
		.bk_st     (bk_st)
	);

	// A popped test enters the first lane stage at the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_st.pop_test |=> bk_st.valid_s1)
		else $error("popped test did not enter the lane stage");

	// A load never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(bk_st.pop && !bk_st.pop_test) |=> !bk_st.valid_s1)
		else $error("load transaction entered the result path");

	// Queue occupancy tracks pushes alone when nothing is popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_st.count == $past(q_st.count) + 1'b1))
		else $error("queue count lost a push");

	// Never pop an empty queue, never push a full one.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_st.empty) && !(push && q_st.full))
		else $error("queue overflow or underflow");

endmodule
`default_nettype wire
